FILE: design/fixed_point_matrix_vector_multiply_unit_macros.svh
// assertion helpers used by the top-level design file
// each expects clk and rst_n in scope
`ifndef FIXED_POINT_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define FIXED_POINT_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

// same-cycle implication
`define FPMV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fpmv_pkg.sv
`timescale 1ns / 1ps

package fpmv_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 32;
    localparam int FRAC_BITS = 16;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int CNT_W  = 6;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 5;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_LOAD_MAT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_VEC = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // one multiply-accumulate step issued by the sequencer
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_col;
        logic             zero;
        logic [ROW_W-1:0] row;
        logic             last_row;
    } tag_t;

    // finished row coming out of the datapath
    typedef struct packed {
        logic              pending;
        logic              done;
        logic [ROW_W-1:0]  row;
        logic              last_row;
        logic [DATA_W-1:0] value;
        logic              clip;
    } res_t;

endpackage

FILE: design/fpmv_store.sv
`timescale 1ns / 1ps

module fpmv_store
(
    input  logic                           clk,
    input  logic                           mat_we,
    input  logic [fpmv_pkg::ADDR_W-1:0]    mat_waddr,
    input  logic                           vec_we,
    input  logic [fpmv_pkg::COL_W-1:0]     vec_waddr,
    input  logic [fpmv_pkg::DATA_W-1:0]    wdata,
    input  logic                           re,
    input  logic [fpmv_pkg::ROW_W-1:0]     rd_row,
    input  logic [fpmv_pkg::COL_W-1:0]     rd_col,
    output logic [fpmv_pkg::DATA_W-1:0]    mat_rdata,
    output logic [fpmv_pkg::DATA_W-1:0]    vec_rdata
);

    logic [fpmv_pkg::DATA_W-1:0] mat_mem [fpmv_pkg::MAT_DEPTH];
    logic [fpmv_pkg::DATA_W-1:0] vec_mem [fpmv_pkg::MAX_COLS];
    logic [fpmv_pkg::DATA_W-1:0] mat_rdata_reg;
    logic [fpmv_pkg::DATA_W-1:0] vec_rdata_reg;

    // row-major matrix, one read port shared by all rows
    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= wdata;
        end
        if (re)
        begin
            mat_rdata_reg <= mat_mem[{rd_row, rd_col}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[vec_waddr] <= wdata;
        end
        if (re)
        begin
            vec_rdata_reg <= vec_mem[rd_col];
        end
    end

    assign mat_rdata = mat_rdata_reg;
    assign vec_rdata = vec_rdata_reg;

endmodule

FILE: design/fpmv_mac.sv
`timescale 1ns / 1ps

module fpmv_mac
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  fpmv_pkg::tag_t               issue,
    input  logic [fpmv_pkg::DATA_W-1:0]  mat_data,
    input  logic [fpmv_pkg::DATA_W-1:0]  vec_data,
    output fpmv_pkg::res_t               res
);

    fpmv_pkg::tag_t                     tag1_reg;
    fpmv_pkg::tag_t                     tag2_reg;
    logic signed [fpmv_pkg::ACC_W-1:0]  prod_reg;
    logic signed [fpmv_pkg::ACC_W-1:0]  prod_next;
    logic signed [fpmv_pkg::ACC_W-1:0]  acc_reg;
    logic signed [fpmv_pkg::ACC_W-1:0]  acc_next;
    logic signed [fpmv_pkg::ACC_W-1:0]  shifted;
    logic                               done_reg;
    logic [fpmv_pkg::ROW_W-1:0]         row3_reg;
    logic                               last3_reg;
    logic                               in_range;

    // stage 2: full 64-bit product, forced to zero when no columns are in use
    assign prod_next = tag1_reg.zero ? '0
                     : fpmv_pkg::ACC_W'($signed(mat_data))
                       * fpmv_pkg::ACC_W'($signed(vec_data));

    // stage 3: scale back to q16.16 and accumulate, wrapping at 64 bits
    assign shifted  = prod_reg >>> fpmv_pkg::FRAC_BITS;
    assign acc_next = (tag2_reg.first ? '0 : acc_reg) + shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg  <= '0;
            tag2_reg  <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
            row3_reg  <= '0;
            last3_reg <= 1'b0;
        end
        else if (adv)
        begin
            tag1_reg <= issue;
            tag2_reg <= tag1_reg;
            done_reg <= tag2_reg.valid && tag2_reg.last_col;
            if (tag2_reg.valid)
            begin
                acc_reg   <= acc_next;
                row3_reg  <= tag2_reg.row;
                last3_reg <= tag2_reg.last_row;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    // fits in 32 bits when the top 33 bits agree
    assign in_range = (acc_reg[fpmv_pkg::ACC_W-1:fpmv_pkg::DATA_W-1] == '0)
                   || (acc_reg[fpmv_pkg::ACC_W-1:fpmv_pkg::DATA_W-1] == '1);

    always_comb
    begin
        res.pending  = tag1_reg.valid || tag2_reg.valid || done_reg;
        res.done     = done_reg;
        res.row      = row3_reg;
        res.last_row = last3_reg;
        res.clip     = !in_range;
        if (in_range)
        begin
            res.value = acc_reg[fpmv_pkg::DATA_W-1:0];
        end
        else if (acc_reg[fpmv_pkg::ACC_W-1])
        begin
            res.value = {1'b1, {(fpmv_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            res.value = {1'b0, {(fpmv_pkg::DATA_W-1){1'b1}}};
        end
    end

endmodule

FILE: design/fixed_point_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps
// channel  | dir | signals                        | meaning
// ---------+-----+--------------------------------+------------------------------------
// s        | in  | s_tvalid s_tready s_tdata s_tuser | load or compute request
// m        | out | m_tvalid m_tready m_tdata m_tuser m_tlast | one result per row
// cfg      | in  | cfg_we cfg_addr cfg_data       | row_count (0), column_count (1)
//
// loads are accepted back to back while no compute is busy
// a compute walks one matrix element per cycle while the output is not stalled,
//   rows * max(cols, 1) elements in all, then drains the read / multiply /
//   accumulate pipe before the input reopens; the single read port of the
//   matrix memory and the one multiplier set that rate
// reset clears counts to 32 and the sequencer; memory contents start undefined
// a stalled result freezes the whole pipe; a new request is taken once the
//   pipe is empty, even while the last result still waits in the output register

`include "fixed_point_matrix_vector_multiply_unit_macros.svh"

module fixed_point_matrix_vector_multiply_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [4:0] row_index, [9:5] col_index, [41:10] element, [47:42] zero
    input  logic [fpmv_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] op
    input  logic [fpmv_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] out_row, [36:5] out_value, [39:37] zero
    output logic [fpmv_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // [0] clamped
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [fpmv_pkg::CNT_W-1:0]        cfg_data
);

    // request fields
    logic [fpmv_pkg::OP_W-1:0]    op;
    logic [fpmv_pkg::IDX_W-1:0]   row_index;
    logic [fpmv_pkg::IDX_W-1:0]   col_index;
    logic [fpmv_pkg::DATA_W-1:0]  element;
    logic                         accept;
    logic                         start_run;

    // configuration
    logic [fpmv_pkg::CNT_W-1:0]   row_count_reg;
    logic [fpmv_pkg::CNT_W-1:0]   col_count_reg;
    logic [fpmv_pkg::CNT_W-1:0]   rows_eff;
    logic [fpmv_pkg::CNT_W-1:0]   cols_eff;

    // sequencer
    logic                         busy_reg;
    logic                         busy_next;
    logic                         issue_reg;
    logic                         issue_next;
    logic [fpmv_pkg::ROW_W-1:0]   row_reg;
    logic [fpmv_pkg::ROW_W-1:0]   row_next;
    logic [fpmv_pkg::COL_W-1:0]   col_reg;
    logic [fpmv_pkg::COL_W-1:0]   col_next;
    logic [fpmv_pkg::CNT_W-1:0]   rows_reg;
    logic [fpmv_pkg::CNT_W-1:0]   cols_reg;
    logic                         zero_reg;
    logic                         at_last_col;
    logic                         at_last_row;
    logic                         adv;
    fpmv_pkg::tag_t               issue;

    // memories and datapath
    logic                         mat_we;
    logic                         vec_we;
    logic                         load_ok;
    logic [fpmv_pkg::DATA_W-1:0]  mat_rdata;
    logic [fpmv_pkg::DATA_W-1:0]  vec_rdata;
    fpmv_pkg::res_t               res;

    // output register
    logic                         m_valid_reg;
    logic [fpmv_pkg::ROW_W-1:0]   out_row_reg;
    logic [fpmv_pkg::DATA_W-1:0]  out_value_reg;
    logic                         clip_reg;
    logic                         last_reg;

    assign op        = s_tuser;
    assign row_index = s_tdata[4:0];
    assign col_index = s_tdata[9:5];
    assign element   = s_tdata[41:10];

    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;

    // counts above the store size saturate
    assign rows_eff = (row_count_reg > fpmv_pkg::CNT_W'(fpmv_pkg::MAX_ROWS))
                    ? fpmv_pkg::CNT_W'(fpmv_pkg::MAX_ROWS) : row_count_reg;
    assign cols_eff = (col_count_reg > fpmv_pkg::CNT_W'(fpmv_pkg::MAX_COLS))
                    ? fpmv_pkg::CNT_W'(fpmv_pkg::MAX_COLS) : col_count_reg;

    // a compute with no rows produces nothing and never goes busy
    assign start_run = accept && (op == fpmv_pkg::OP_COMPUTE) && (rows_eff != '0);

    // loads outside the store are dropped
    assign load_ok = (int'(row_index) < fpmv_pkg::MAX_ROWS)
                  && (int'(col_index) < fpmv_pkg::MAX_COLS);
    assign mat_we  = accept && (op == fpmv_pkg::OP_LOAD_MAT) && load_ok;
    assign vec_we  = accept && (op == fpmv_pkg::OP_LOAD_VEC)
                  && (int'(col_index) < fpmv_pkg::MAX_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= fpmv_pkg::CNT_W'(32);
            col_count_reg <= fpmv_pkg::CNT_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fpmv_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data;
                fpmv_pkg::CFG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves only when the output register can take a new row
    assign adv = !m_valid_reg || m_tready;

    assign at_last_col = (fpmv_pkg::CNT_W'(col_reg) == cols_reg - fpmv_pkg::CNT_W'(1));
    assign at_last_row = (fpmv_pkg::CNT_W'(row_reg) == rows_reg - fpmv_pkg::CNT_W'(1));

    always_comb
    begin
        issue.valid    = issue_reg && adv;
        issue.first    = (col_reg == '0);
        issue.last_col = at_last_col;
        issue.zero     = zero_reg;
        issue.row      = row_reg;
        issue.last_row = at_last_row;
    end

    // walk row-major over the elements in use, one per advancing cycle
    always_comb
    begin
        busy_next  = busy_reg;
        issue_next = issue_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (start_run)
        begin
            busy_next  = 1'b1;
            issue_next = 1'b1;
            row_next   = '0;
            col_next   = '0;
        end
        else if (issue_reg)
        begin
            if (adv)
            begin
                if (at_last_col)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    if (at_last_row)
                    begin
                        issue_next = 1'b0;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
        else if (busy_reg && !res.pending)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            rows_reg  <= '0;
            cols_reg  <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            issue_reg <= issue_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (start_run)
            begin
                rows_reg <= rows_eff;
                // zero columns: one forced-zero step per row
                cols_reg <= (cols_eff == '0) ? fpmv_pkg::CNT_W'(1) : cols_eff;
                zero_reg <= (cols_eff == '0);
            end
        end
    end

    fpmv_store u_store
    (
        .clk       (clk),
        .mat_we    (mat_we),
        .mat_waddr ({row_index[fpmv_pkg::ROW_W-1:0], col_index[fpmv_pkg::COL_W-1:0]}),
        .vec_we    (vec_we),
        .vec_waddr (col_index[fpmv_pkg::COL_W-1:0]),
        .wdata     (element),
        .re        (issue.valid),
        .rd_row    (row_reg),
        .rd_col    (col_reg),
        .mat_rdata (mat_rdata),
        .vec_rdata (vec_rdata)
    );

    fpmv_mac u_mac
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .issue    (issue),
        .mat_data (mat_rdata),
        .vec_data (vec_rdata),
        .res      (res)
    );

    // output register, loaded from the clamp stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= res.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res.done)
        begin
            out_row_reg   <= res.row;
            out_value_reg <= res.value;
            clip_reg      <= res.clip;
            last_reg      <= res.last_row;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_value_reg, out_row_reg};
    assign m_tuser  = clip_reg;
    assign m_tlast  = last_reg;

    `FPMV_ASSERT_NEXT(a_run_goes_busy, start_run, busy_reg && issue_reg, "compute did not start")
    `FPMV_ASSERT_IMPL(a_issue_blocks_input, issue_reg, busy_reg && !s_tready, "request taken mid-run")
    `FPMV_ASSERT_IMPL(a_row_order, adv && res.done && m_valid_reg && !last_reg, res.row == (out_row_reg + 1'b1), "rows out of order")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    // op code 3 has no function in the block, used as noise
    localparam logic [fpmv_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    // side of the square corner of the matrix that random traffic works in
    localparam int WINDOW = 4;

    // quiet cycles allowed before an idle config write and at the end
    // (a compute walks every element in use before its pipe drains, a zero-row compute never starts)
    localparam int SETTLE_CYCLES = 40;
    // no handshake or config write for this long means the block is stuck
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [fpmv_pkg::IDX_W-1:0]         row;
        logic signed [fpmv_pkg::DATA_W-1:0] value;
        logic                               clip;
        logic                               is_last;
    } row_result_t;

    // clock, reset and block ports
    logic                              clk;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [fpmv_pkg::IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [fpmv_pkg::OP_W-1:0]         s_tuser  = fpmv_pkg::OP_LOAD_MAT;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [fpmv_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                              m_tuser;
    logic                              m_tlast;
    logic                              cfg_we   = 1'b0;
    logic                              cfg_addr = fpmv_pkg::CFG_ROW_COUNT;
    logic [fpmv_pkg::CNT_W-1:0]        cfg_data = '0;

    // shadow copy of the block's stores and count registers
    logic signed [fpmv_pkg::DATA_W-1:0] mat_shadow [fpmv_pkg::MAX_ROWS][fpmv_pkg::MAX_COLS];
    logic signed [fpmv_pkg::DATA_W-1:0] vec_shadow [fpmv_pkg::MAX_COLS];
    logic [fpmv_pkg::CNT_W-1:0]         rows_cfg = fpmv_pkg::CNT_W'(32);
    logic [fpmv_pkg::CNT_W-1:0]         cols_cfg = fpmv_pkg::CNT_W'(32);

    // row results still owed by the block, oldest first
    row_result_t pending_rows[$];
    row_result_t oldest;

    // idle mix of both sides, in percent
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // a nonzero value asks the receiver for a long hold-off
    int hold_request  = 0;
    int hold_left     = 0;

    int quiet_cycles  = 0;
    int mismatches    = 0;
    int n_requests    = 0;
    int n_computes    = 0;
    int n_results     = 0;
    int n_clamped     = 0;

    fixed_point_matrix_vector_multiply_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // shadow model: loads update the stores, a compute predicts one result per row
    task automatic predict_request(input logic [fpmv_pkg::OP_W-1:0] op,
                                   input logic [fpmv_pkg::IDX_W-1:0] ri,
                                   input logic [fpmv_pkg::IDX_W-1:0] ci,
                                   input logic [fpmv_pkg::DATA_W-1:0] elem);
        int rows;
        int cols;
        logic signed [fpmv_pkg::ACC_W-1:0] prod;
        logic signed [fpmv_pkg::ACC_W-1:0] sum;
        row_result_t res;
        case (op)
            fpmv_pkg::OP_LOAD_MAT: mat_shadow[ri][ci] = elem;
            fpmv_pkg::OP_LOAD_VEC: vec_shadow[ci] = elem;
            fpmv_pkg::OP_COMPUTE:
            begin
                n_computes++;
                // counts above the store size saturate
                rows = (rows_cfg > fpmv_pkg::MAX_ROWS) ? fpmv_pkg::MAX_ROWS : int'(rows_cfg);
                cols = (cols_cfg > fpmv_pkg::MAX_COLS) ? fpmv_pkg::MAX_COLS : int'(cols_cfg);
                for (int r = 0; r < rows; r++)
                begin
                    sum = '0;
                    for (int c = 0; c < cols; c++)
                    begin
                        // full 64-bit product, arithmetic shift drops the fraction
                        prod = mat_shadow[r][c] * vec_shadow[c];
                        sum  = sum + (prod >>> fpmv_pkg::FRAC_BITS);
                    end
                    res.row     = fpmv_pkg::IDX_W'(r);
                    res.is_last = (r == rows - 1);
                    if (sum > 64'sd2147483647)
                    begin
                        res.value = 32'h7fff_ffff;
                        res.clip  = 1'b1;
                    end
                    else if (sum < -64'sd2147483648)
                    begin
                        res.value = 32'h8000_0000;
                        res.clip  = 1'b1;
                    end
                    else
                    begin
                        res.value = sum[fpmv_pkg::DATA_W-1:0];
                        res.clip  = 1'b0;
                    end
                    pending_rows.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // one request on the input stream, with a random lead-in gap
    task automatic send_request(input logic [fpmv_pkg::OP_W-1:0] op,
                                input logic [fpmv_pkg::IDX_W-1:0] ri,
                                input logic [fpmv_pkg::IDX_W-1:0] ci,
                                input logic [fpmv_pkg::DATA_W-1:0] elem);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(fpmv_pkg::IN_TDATA_W - 42){1'b0}}, elem, ci, ri};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_request(op, ri, ci, elem);
        n_requests++;
    endtask

    // drop valid, wait for every owed result, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one count register alone, the other keeps its value
    task automatic write_count(input logic idx, input logic [fpmv_pkg::CNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == fpmv_pkg::CFG_ROW_COUNT)
            rows_cfg = value;
        else
            cols_cfg = value;
        @(posedge clk);
    endtask

    // both count registers, written back to back while the block is idle
    task automatic set_counts(input logic [fpmv_pkg::CNT_W-1:0] rows,
                              input logic [fpmv_pkg::CNT_W-1:0] cols);
        cfg_we   <= 1'b1;
        cfg_addr <= fpmv_pkg::CFG_ROW_COUNT;
        cfg_data <= rows;
        @(posedge clk);
        cfg_addr <= fpmv_pkg::CFG_COL_COUNT;
        cfg_data <= cols;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rows_cfg = rows;
        cols_cfg = cols;
        @(posedge clk);
    endtask

    // Q16.16 values: extremes, full range, small and moderate magnitudes
    function automatic logic [fpmv_pkg::DATA_W-1:0] rand_element();
        int v;
        case ($urandom_range(9))
            0: v = 32'h7fff_ffff;
            1: v = 32'h8000_0000;
            2, 3: v = $urandom;
            4, 5, 6: v = int'($urandom_range(1 << 19)) - (1 << 18);
            default: v = int'($urandom_range(1 << 25)) - (1 << 24);
        endcase
        return v;
    endfunction

    // counts inside the written corner, now and then zero
    function automatic logic [fpmv_pkg::CNT_W-1:0] pick_count();
        if ($urandom_range(9) == 0)
            return '0;
        return fpmv_pkg::CNT_W'($urandom_range(WINDOW, 1));
    endfunction

    // column count at its reset value of 32: row 0 against the whole vector
    task automatic test_reset_columns();
        for (int c = 0; c < fpmv_pkg::MAX_COLS; c++)
            send_request(fpmv_pkg::OP_LOAD_MAT, '0, fpmv_pkg::IDX_W'(c), rand_element());
        for (int c = 0; c < fpmv_pkg::MAX_COLS; c++)
            send_request(fpmv_pkg::OP_LOAD_VEC, fpmv_pkg::IDX_W'($urandom),
                         fpmv_pkg::IDX_W'(c), rand_element());
        wait_drained();
        write_count(fpmv_pkg::CFG_ROW_COUNT, fpmv_pkg::CNT_W'(1));
        send_request(fpmv_pkg::OP_COMPUTE, fpmv_pkg::IDX_W'($urandom),
                     fpmv_pkg::IDX_W'($urandom), $urandom);
        wait_drained();
    endtask

    // fill the rest of the square corner below row 0, which later tests read from
    task automatic test_window();
        for (int r = 1; r < WINDOW; r++)
            for (int c = 0; c < WINDOW; c++)
                send_request(fpmv_pkg::OP_LOAD_MAT, fpmv_pkg::IDX_W'(r),
                             fpmv_pkg::IDX_W'(c), rand_element());
        wait_drained();
        set_counts(fpmv_pkg::CNT_W'(WINDOW), fpmv_pkg::CNT_W'(WINDOW));
        send_request(fpmv_pkg::OP_COMPUTE, '0, '0, '0);
        wait_drained();
    endtask

    // exact limits without clamping, clamping both ways, ignored fields
    task automatic test_clamp_edges();
        set_counts(fpmv_pkg::CNT_W'(4), fpmv_pkg::CNT_W'(2));
        // vector: largest and smallest value
        send_request(fpmv_pkg::OP_LOAD_VEC, 5'd31, 5'd0, 32'h7fff_ffff);
        send_request(fpmv_pkg::OP_LOAD_VEC, 5'd0,  5'd1, 32'h8000_0000);
        // row 0 lands exactly on the positive limit
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd0, 5'd0, 32'h0001_0000);
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd0, 5'd1, 32'h0000_0000);
        // row 1 lands exactly on the negative limit
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd1, 5'd0, 32'h0000_0000);
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd1, 5'd1, 32'h0001_0000);
        // row 2 far past the positive limit
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd2, 5'd0, 32'h0001_0000);
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd2, 5'd1, 32'hffff_0000);
        // row 3 far below the negative limit, with a tiny negative element
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd3, 5'd0, 32'h8000_0000);
        send_request(fpmv_pkg::OP_LOAD_MAT, 5'd3, 5'd1, 32'hffff_ffff);
        // unused op must leave the stores alone
        send_request(OP_UNUSED, 5'd31, 5'd0, 32'hffff_ffff);
        send_request(fpmv_pkg::OP_COMPUTE, 5'd31, 5'd31, 32'hffff_ffff);
        wait_drained();
    endtask

    // zero, oversized and single-element counts
    task automatic test_count_corners();
        set_counts(fpmv_pkg::CNT_W'(0), fpmv_pkg::CNT_W'(5));
        send_request(fpmv_pkg::OP_COMPUTE, '0, '0, '0);
        wait_drained();
        set_counts(fpmv_pkg::CNT_W'(1), fpmv_pkg::CNT_W'(0));
        send_request(fpmv_pkg::OP_COMPUTE, '0, '0, '0);
        wait_drained();
        // rows saturate to 32, no columns: every row sums to zero
        set_counts(fpmv_pkg::CNT_W'(40), fpmv_pkg::CNT_W'(0));
        send_request(fpmv_pkg::OP_COMPUTE, '0, '0, '0);
        wait_drained();
        // columns saturate to 32 on row 0
        set_counts(fpmv_pkg::CNT_W'(1), fpmv_pkg::CNT_W'(63));
        send_request(fpmv_pkg::OP_COMPUTE, '0, '0, '0);
        wait_drained();
    endtask

    // loads inside the active window, some anywhere, noise and computes
    task automatic test_random_traffic(input int n_items);
        int kind;
        int rmax;
        int cmax;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 7 == 0)
            begin
                wait_drained();
                set_counts(pick_count(), pick_count());
            end
            rmax = (rows_cfg == 0) ? 1 : int'(rows_cfg);
            cmax = (cols_cfg == 0) ? 1 : int'(cols_cfg);
            kind = $urandom_range(99);
            if (kind < 45)
                send_request(fpmv_pkg::OP_LOAD_MAT, fpmv_pkg::IDX_W'($urandom_range(rmax - 1)),
                             fpmv_pkg::IDX_W'($urandom_range(cmax - 1)), rand_element());
            else if (kind < 65)
                send_request(fpmv_pkg::OP_LOAD_VEC, fpmv_pkg::IDX_W'($urandom),
                             fpmv_pkg::IDX_W'($urandom_range(cmax - 1)), rand_element());
            else if (kind < 75)
                send_request($urandom_range(1) ? fpmv_pkg::OP_LOAD_VEC : fpmv_pkg::OP_LOAD_MAT,
                             fpmv_pkg::IDX_W'($urandom), fpmv_pkg::IDX_W'($urandom),
                             rand_element());
            else if (kind < 80)
                send_request(OP_UNUSED, fpmv_pkg::IDX_W'($urandom),
                             fpmv_pkg::IDX_W'($urandom), $urandom);
            else
                send_request(fpmv_pkg::OP_COMPUTE, fpmv_pkg::IDX_W'($urandom),
                             fpmv_pkg::IDX_W'($urandom), $urandom);
        end
    endtask

    // long output stall while requests keep coming, then a full pause
    task automatic test_backpressure();
        wait_drained();
        set_counts(fpmv_pkg::CNT_W'(WINDOW), fpmv_pkg::CNT_W'(2));
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 6; i++)
        begin
            send_request(fpmv_pkg::OP_LOAD_VEC, fpmv_pkg::IDX_W'($urandom),
                         fpmv_pkg::IDX_W'(i % 2), rand_element());
            send_request(fpmv_pkg::OP_COMPUTE, fpmv_pkg::IDX_W'($urandom),
                         fpmv_pkg::IDX_W'($urandom), $urandom);
        end
        // sender waits for the whole backlog before the next burst
        wait_drained();
        for (int i = 0; i < 4; i++)
            send_request(fpmv_pkg::OP_COMPUTE, fpmv_pkg::IDX_W'($urandom),
                         fpmv_pkg::IDX_W'($urandom), $urandom);
    endtask

    // receiver: random stalls, or a counted hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request > 0)
        begin
            m_tready     <= 1'b0;
            hold_left    <= hold_request;
            hold_request = 0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker: each accepted result against the oldest owed row
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (m_tuser)
                n_clamped++;
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("tb: unexpected result row %0d value %h clamped %b last %b",
                             m_tdata[4:0], m_tdata[36:5], m_tuser, m_tlast);
            end
            else
            begin
                oldest = pending_rows.pop_front();
                if (m_tdata[4:0] !== oldest.row || m_tdata[36:5] !== oldest.value ||
                    m_tuser !== oldest.clip || m_tlast !== oldest.is_last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("tb: mismatch at %0t: exp row %0d value %h clamped %b last %b",
                                 $realtime, oldest.row, oldest.value, oldest.clip,
                                 oldest.is_last);
                        $display("tb:   got row %0d value %h clamped %b last %b",
                                 m_tdata[4:0], m_tdata[36:5], m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    // watchdog: any handshake or config write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: no progress for %0d cycles, %0d results still owed",
                     quiet_cycles, pending_rows.size());
            $display("tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 20;
        recv_idle_pct = 45;
        test_reset_columns();
        test_window();
        test_clamp_edges();
        test_count_corners();
        test_random_traffic(14);

        // the other way round
        send_idle_pct = 45;
        recv_idle_pct = 20;
        test_random_traffic(14);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(14);
        test_backpressure();

        wait_drained();
        $display("tb: %0d requests, %0d computes, %0d row results (%0d clamped)",
                 n_requests, n_computes, n_results, n_clamped);
        $display("tb: counts 0..63, clamp limits, three idle mixes, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
